### rtl/ptm_pkg.sv
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared constants, codes and helpers for the four-level page table manager.
// ----------------------------------------------------------------------------
package ptm_pkg;

   // Table store geometry
   localparam int TABLE_COUNT = 64;
   localparam int TBL_W       = $clog2(TABLE_COUNT);
   localparam int CNT_W       = $clog2(TABLE_COUNT + 1);
   localparam int IDX_W       = 9;
   localparam int MEM_AW      = TBL_W + IDX_W;
   localparam int MEM_DEPTH   = TABLE_COUNT * 512;
   localparam int PAGE_W      = 40;

   // Operation codes
   localparam logic [1:0] FUNC_TRANSLATE = 2'd0;
   localparam logic [1:0] FUNC_MAP       = 2'd1;
   localparam logic [1:0] FUNC_UNMAP     = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_NOT_PRESENT = 2'd1;
   localparam logic [1:0] STATUS_NO_TABLES   = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_DM_BASE    = 2'd0;
   localparam logic [1:0] CSR_DM_PAGES   = 2'd1;
   localparam logic [1:0] CSR_TABLE_BASE = 2'd2;

   // Reset page number of table 0 (0x200000 >> 12)
   localparam logic [PAGE_W-1:0] TABLE_BASE_PAGE_RESET = 40'h200;

   // Pointer entries carry present and writable
   localparam logic [11:0] PTR_FLAGS = 12'h003;

   // Level walk: 0 is the root, 3 the leaf table
   localparam logic [1:0] LVL_ROOT = 2'd0;
   localparam logic [1:0] LVL_PD   = 2'd2;
   localparam logic [1:0] LVL_LEAF = 2'd3;

   // Pick the 9-bit table index of a level out of the virtual address
   function automatic logic [IDX_W-1:0] level_index(input logic [63:0] va,
                                                     input logic [1:0]  lvl);
      logic [IDX_W-1:0] idx;
      unique case (lvl)
         2'd0:    idx = va[47:39];
         2'd1:    idx = va[38:30];
         2'd2:    idx = va[29:21];
         default: idx = va[20:12];
      endcase
      return idx;
   endfunction

endpackage

### rtl/four_level_page_table_manager_core.sv
// ----------------------------------------------------------------------------
// four_level_page_table_manager_core
// Four-level radix page tables kept in one on-chip table memory, serving
// translate, map and unmap items one at a time.
// ----------------------------------------------------------------------------
// Sequence: a direct-map hit or an unknown operation goes straight to the
//   result; each table read takes S_RD and S_EV, each allocation S_ALLOC,
//   the leaf write S_LEAF. Items are taken one at a time; req_tready stays
//   low until the result is loaded into the output register.
// Reset: synchronous; a clearing pass then writes all 32768 entries, one per
//   cycle, with req_tready low; register writes are taken during the pass.
// ----------------------------------------------------------------------------
module four_level_page_table_manager_core (
   input  logic         clock,
   input  logic         reset,
   // Configuration write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_addr,
   input  logic [63:0]  csr_wdata,
   // Request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // virt_addr[63:0], phys_addr[115:64], entry_flags[127:116]
   input  logic [1:0]   req_tuser,   // func[1:0]
   // Response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata,   // result_addr[51:0], zero pad[55:52]
   output logic [1:0]   rsp_tuser    // status[1:0]
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DISP,
      S_RD,
      S_EV,
      S_ALLOC,
      S_LEAF,
      S_DONE
   } state_type;

   state_type state_ff;

   // Sweep pointer for the post-reset clearing pass
   logic [ptm_pkg::MEM_AW-1:0] clr_addr_ff;

   // Configuration registers
   logic [63:0]                 dm_base_ff;
   logic [ptm_pkg::PAGE_W-1:0]  dm_pages_ff;
   logic [ptm_pkg::PAGE_W-1:0]  tb_page_ff;

   // Item being worked on
   logic [1:0]                  func_ff;
   logic [63:0]                 va_ff;
   logic [ptm_pkg::PAGE_W-1:0]  pa_page_ff;
   logic [11:0]                 flags_ff;
   logic [63:0]                 dm_diff_ff;

   // Walk state
   logic [1:0]                  lvl_ff;
   logic [ptm_pkg::TBL_W-1:0]   cur_ff;
   logic                        grow_ff;     // map has passed its room check
   logic [ptm_pkg::CNT_W-1:0]   next_table_ff;

   // Result under construction and output register
   logic [51:0]                 res_ff;
   logic [1:0]                  status_ff;
   logic                        rsp_valid_ff;
   logic [51:0]                 rsp_addr_ff;
   logic [1:0]                  rsp_status_ff;
   logic                        rsp_load;

   // Table memory: bit 64 is a mark that tells entries written since the
   // table was allocated from stale ones. A table k counts as allocated when
   // k < next_table; a read whose mark differs from that reads as zero, which
   // stands in for clearing a whole table on allocation.
   logic [64:0]                 table_mem [ptm_pkg::MEM_DEPTH];
   logic [64:0]                 mem_q_ff;
   logic                        mem_we;
   logic [ptm_pkg::MEM_AW-1:0]  mem_waddr;
   logic [64:0]                 mem_wdata;
   logic                        mem_re;
   logic [ptm_pkg::MEM_AW-1:0]  mem_raddr;

   // Decode of the entry just read
   logic [ptm_pkg::IDX_W-1:0]   cur_idx;
   logic                        cur_live;
   logic                        cur_live_after;
   logic [63:0]                 entry;
   logic [ptm_pkg::PAGE_W-1:0]  ptr_off;
   logic                        ptr_ok;
   logic [ptm_pkg::TBL_W-1:0]   ptr_tbl;
   logic [ptm_pkg::CNT_W-1:0]   free_cnt;
   logic [ptm_pkg::CNT_W-1:0]   need_cnt;
   logic                        no_room;
   logic [ptm_pkg::PAGE_W-1:0]  new_page;
   logic                        dm_hit;

   assign cur_idx        = ptm_pkg::level_index(va_ff, lvl_ff);
   assign cur_live       = ptm_pkg::CNT_W'(cur_ff) <  next_table_ff;
   // Mark for a pointer written while next_table advances in the same cycle
   assign cur_live_after = ptm_pkg::CNT_W'(cur_ff) <= next_table_ff;
   assign entry          = (mem_q_ff[64] == cur_live) ? mem_q_ff[63:0] : 64'h0;

   // Pointer decode against the current table base
   assign ptr_off = entry[51:12] - tb_page_ff;
   assign ptr_ok  = entry[0] && (ptr_off < ptm_pkg::PAGE_W'(ptm_pkg::TABLE_COUNT));
   assign ptr_tbl = ptr_off[ptm_pkg::TBL_W-1:0];

   // Room check: tables still missing below the failed level vs tables free
   assign free_cnt = ptm_pkg::CNT_W'(ptm_pkg::TABLE_COUNT) - next_table_ff;
   assign need_cnt = ptm_pkg::CNT_W'(2'd3 - lvl_ff);
   assign no_room  = need_cnt > free_cnt;
   assign new_page = tb_page_ff + ptm_pkg::PAGE_W'(next_table_ff);

   // Direct-map window: difference registered on acceptance, compared here
   assign dm_hit = (dm_base_ff != 64'h0) && (dm_diff_ff[63:52] == 12'h0) &&
                   (dm_diff_ff[51:0] < {dm_pages_ff, 12'h000});

   // Load the output register when the result is ready and the slot is free
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   // Memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {cur_ff, cur_idx};
      mem_wdata = 65'h0;
      mem_re    = 1'b0;
      mem_raddr = {cur_ff, cur_idx};
      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
         end
         S_RD: begin
            mem_re = 1'b1;
         end
         S_ALLOC: begin
            // Link the free table into the walk
            mem_we    = 1'b1;
            mem_wdata = {cur_live_after, 12'h000, new_page, ptm_pkg::PTR_FLAGS};
         end
         S_LEAF: begin
            mem_we = 1'b1;
            if (func_ff == ptm_pkg::FUNC_MAP) begin
               mem_wdata = {cur_live, 12'h000, pa_page_ff, flags_ff[11:1], 1'b1};
            end else begin
               mem_wdata = {cur_live, 64'h0};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= table_mem[mem_raddr];
      end
   end

   // Sequencer, registers and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         dm_base_ff    <= 64'h0;
         dm_pages_ff   <= '0;
         tb_page_ff    <= ptm_pkg::TABLE_BASE_PAGE_RESET;
         next_table_ff <= ptm_pkg::CNT_W'(1);
         lvl_ff        <= ptm_pkg::LVL_ROOT;
         cur_ff        <= '0;
         grow_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // Register writes
         if (csr_valid) begin
            case (csr_addr)
               ptm_pkg::CSR_DM_BASE:    dm_base_ff  <= csr_wdata;
               ptm_pkg::CSR_DM_PAGES:   dm_pages_ff <= csr_wdata[39:0];
               ptm_pkg::CSR_TABLE_BASE: tb_page_ff  <= csr_wdata[51:12];
               default: begin
               end
            endcase
         end

         // Raise the result on load, drop it once taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + ptm_pkg::MEM_AW'(1);
               if (clr_addr_ff == ptm_pkg::MEM_AW'(ptm_pkg::MEM_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end

            S_IDLE: begin
               if (req_tvalid) begin
                  func_ff    <= req_tuser;
                  va_ff      <= req_tdata[63:0];
                  pa_page_ff <= req_tdata[115:76];
                  flags_ff   <= req_tdata[127:116];
                  dm_diff_ff <= req_tdata[63:0] - dm_base_ff;
                  state_ff   <= S_DISP;
               end
            end

            S_DISP: begin
               lvl_ff    <= ptm_pkg::LVL_ROOT;
               cur_ff    <= '0;
               grow_ff   <= 1'b0;
               status_ff <= ptm_pkg::STATUS_OK;
               if (func_ff == ptm_pkg::FUNC_TRANSLATE && dm_hit) begin
                  res_ff   <= dm_diff_ff[51:0];
                  state_ff <= S_DONE;
               end else begin
                  res_ff <= 52'h0;
                  if (func_ff == ptm_pkg::FUNC_TRANSLATE ||
                      func_ff == ptm_pkg::FUNC_MAP ||
                      func_ff == ptm_pkg::FUNC_UNMAP) begin
                     state_ff <= S_RD;
                  end else begin
                     // Unknown operation: answer zero, touch nothing
                     state_ff <= S_DONE;
                  end
               end
            end

            S_RD: begin
               state_ff <= S_EV;
            end

            S_EV: begin
               if (lvl_ff == ptm_pkg::LVL_LEAF) begin
                  // Only translate reads the leaf
                  if (entry[0]) begin
                     res_ff <= {entry[51:12], va_ff[11:0]};
                  end else begin
                     status_ff <= ptm_pkg::STATUS_NOT_PRESENT;
                  end
                  state_ff <= S_DONE;
               end else if (ptr_ok) begin
                  cur_ff <= ptr_tbl;
                  lvl_ff <= lvl_ff + 2'd1;
                  if (lvl_ff == ptm_pkg::LVL_PD && func_ff != ptm_pkg::FUNC_TRANSLATE) begin
                     state_ff <= S_LEAF;
                  end else begin
                     state_ff <= S_RD;
                  end
               end else if (func_ff == ptm_pkg::FUNC_MAP) begin
                  // First miss decides whether the whole map fits
                  if (!grow_ff && no_room) begin
                     status_ff <= ptm_pkg::STATUS_NO_TABLES;
                     state_ff  <= S_DONE;
                  end else begin
                     grow_ff  <= 1'b1;
                     state_ff <= S_ALLOC;
                  end
               end else begin
                  status_ff <= ptm_pkg::STATUS_NOT_PRESENT;
                  state_ff  <= S_DONE;
               end
            end

            S_ALLOC: begin
               // Advance the bump counter and descend into the new table
               next_table_ff <= next_table_ff + ptm_pkg::CNT_W'(1);
               cur_ff        <= next_table_ff[ptm_pkg::TBL_W-1:0];
               lvl_ff        <= lvl_ff + 2'd1;
               if (lvl_ff == ptm_pkg::LVL_PD) begin
                  state_ff <= S_LEAF;
               end else begin
                  state_ff <= S_RD;
               end
            end

            S_LEAF: begin
               state_ff <= S_DONE;
            end

            S_DONE: begin
               // Hold until the output register is free
               if (rsp_load) begin
                  rsp_addr_ff   <= res_ff;
                  rsp_status_ff <= status_ff;
                  state_ff      <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, rsp_addr_ff};
   assign rsp_tuser  = rsp_status_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // The bump counter never runs past the table store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      next_table_ff <= ptm_pkg::CNT_W'(ptm_pkg::TABLE_COUNT))
      else $error("next_table beyond table count");

   // Allocation only happens with a free table left
   a_alloc_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC) |-> (next_table_ff < ptm_pkg::CNT_W'(ptm_pkg::TABLE_COUNT)))
      else $error("allocation without a free table");

   // Tables are never returned
   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (next_table_ff >= $past(next_table_ff)))
      else $error("next_table decreased");

   // A refused map leaves the allocation count untouched
   a_no_tables: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && status_ff == ptm_pkg::STATUS_NO_TABLES && !$past(reset))
      |-> $stable(next_table_ff))
      else $error("refused map changed the table count");

endmodule
